// File: sv/bfknn_pkg.sv
// Package: shared widths, codes and types for the nearest-neighbor search unit.
`timescale 1ns / 1ps
package bfknn_pkg;
  localparam int unsigned MaxDimDefault = 128;
  localparam int unsigned MaxKDefault   = 16;
  localparam int unsigned DistW = 48;
  localparam int unsigned IdW   = 24;
  localparam int unsigned ValW  = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegKInUse  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegVecLen  = 1'd1;

  typedef enum logic [1:0] {
    ModeQuery = 2'd0,
    ModeBase  = 2'd1,
    ModeEmit  = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StQRead,
    StAcc,
    StRescan,
    StEmitScan,
    StEmitOut
  } state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ValW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [IdW-1:0]   vector_id;
    logic             found;
    logic             last;
  } out_item_t;
endpackage

// File: sv/bfknn_if.sv
// Interfaces: valid/ready channels for input items and result items.
`timescale 1ns / 1ps
interface bfknn_in_if;
  logic                   valid;
  logic                   ready;
  bfknn_pkg::in_item_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bfknn_out_if;
  logic                   valid;
  logic                   ready;
  bfknn_pkg::out_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/bfknn_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bfknn_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: sv/brute_force_knn_topk_unit.sv
// Top level: exact k-nearest-neighbor search with squared Euclidean distance.
// Mode 0 loads query elements (Q8.8) one at a time; element 0 clears the search.
// Mode 1 streams base elements: each goes through a query RAM read, then one
// shared 17x17 squarer feeding a 48-bit saturating accumulator. The last
// element of a vector also offers the candidate to a top-k store of MAX_K
// entries; a replacement then rescans the store one entry per cycle with a
// single compare unit. Mode 2 emits the candidates in ascending distance
// (ties to lower id), or one not-found item when the store is empty: each
// result is found by a selection scan using the same compare unit.
// Ready is low while an item is in work.
`timescale 1ns / 1ps
module brute_force_knn_topk_unit #(
  parameter int unsigned MaxDim = bfknn_pkg::MaxDimDefault,
  parameter int unsigned MaxK   = bfknn_pkg::MaxKDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfknn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bfknn_pkg::CfgDataW-1:0] cfg_data_i,
  bfknn_in_if.sink                       in_if,
  bfknn_out_if.source                    out_if
);
  localparam int unsigned DimAw = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned KAw   = (MaxK > 1) ? $clog2(MaxK) : 1;
  localparam int unsigned CntW  = $clog2(MaxK + 1);
  localparam int unsigned DW    = bfknn_pkg::DistW;
  localparam int unsigned IW    = bfknn_pkg::IdW;
  localparam int unsigned PosW  = 8;

  localparam logic [DW-1:0] DistMax = {DW{1'b1}};

  bfknn_pkg::state_e state_q, state_d;

  logic [4:0]      k_q;
  logic [7:0]      len_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [DW-1:0]   acc_q, acc_d;
  logic [IW-1:0]   vid_q, vid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   worst_q, worst_d;
  logic [15:0]     val_q, val_d;
  logic            lastel_q, lastel_d;

  // candidate store, held in flops (read at scan index and written at slot)
  logic [DW-1:0] cd_q [MaxK];
  logic [IW-1:0] ci_q [MaxK];
  logic          cwe;
  logic [KAw-1:0] cw_idx;
  logic [DW-1:0] cw_dist;

  // scan unit
  logic [KAw-1:0] sc_q, sc_d;
  logic [KAw-1:0] best_q, best_d;
  logic [DW-1:0]  bd_q, bd_d;
  logic [IW-1:0]  bi_q, bi_d;
  logic [CntW-1:0] emitted_q, emitted_d;
  // previous emitted key for selection order
  logic [DW-1:0]  pd_q, pd_d;
  logic [IW-1:0]  pi_q, pi_d;
  logic [KAw-1:0] pk_q, pk_d;
  logic           have_best_q, have_best_d;

  logic            ram_we;
  logic [DimAw-1:0] ram_addr;
  logic [15:0]     ram_rdata;

  bfknn_pkg::out_item_t oitem_q, oitem_d;
  logic ovalid_q, ovalid_d;

  // effective config
  logic [PosW:0] eff_len;
  logic [CntW-1:0] eff_k;
  always_comb begin
    if (len_q == '0) eff_len = 9'd1;
    else if (32'(len_q) > 32'(MaxDim)) eff_len = 9'(MaxDim);
    else eff_len = {1'b0, len_q};
    if (k_q == '0) eff_k = CntW'(1);
    else if (32'(k_q) > 32'(MaxK)) eff_k = CntW'(MaxK);
    else eff_k = CntW'(k_q);
  end

  logic at_end;
  assign at_end = ({1'b0, pos_q} + 9'd1) >= eff_len;

  bfknn_ram #(.Width(16), .Depth(MaxDim)) u_qram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (val_q),
    .rdata_o (ram_rdata)
  );
  // position never reaches MaxDim: it only advances below the effective length
  assign ram_addr = DimAw'(pos_q);

  // shared squarer, combinational
  logic signed [16:0] diff;
  logic [33:0]        sq;
  assign diff = $signed({ram_rdata[15], ram_rdata}) - $signed({val_q[15], val_q});
  assign sq   = 34'($signed(diff) * $signed(diff));

  // shared compare: scanned entry vs running best
  logic [DW-1:0] s_dist;
  logic [IW-1:0] s_id;
  assign s_dist = cd_q[sc_q];
  assign s_id   = ci_q[sc_q];

  // entry strictly after previously emitted key in (dist,id,idx) order
  logic after_prev, before_best;
  always_comb begin
    if (emitted_q == '0) after_prev = 1'b1;
    else if (s_dist != pd_q) after_prev = s_dist > pd_q;
    else if (s_id != pi_q) after_prev = s_id > pi_q;
    else after_prev = sc_q > pk_q;
    if (!have_best_q) before_best = 1'b1;
    else if (s_dist != bd_q) before_best = s_dist < bd_q;
    else before_best = s_id < bi_q;
  end

  logic sc_last;
  assign sc_last = (CntW'(sc_q) + CntW'(1)) >= cnt_q;

  always_comb begin
    state_d = state_q;
    pos_d = pos_q; acc_d = acc_q; vid_d = vid_q; cnt_d = cnt_q; worst_d = worst_q;
    val_d = val_q; lastel_d = lastel_q;
    sc_d = sc_q; best_d = best_q; bd_d = bd_q; bi_d = bi_q;
    emitted_d = emitted_q; pd_d = pd_q; pi_d = pi_q; pk_d = pk_q;
    have_best_d = have_best_q;
    oitem_d = oitem_q; ovalid_d = ovalid_q;
    ram_we = 1'b0;
    cwe = 1'b0; cw_idx = '0; cw_dist = acc_q;
    in_if.ready = 1'b0;

    if (ovalid_q && out_if.ready) ovalid_d = 1'b0;

    unique case (state_q)
      bfknn_pkg::StIdle: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          val_d = in_if.payload.value;
          unique case (bfknn_pkg::mode_e'(in_if.payload.mode))
            bfknn_pkg::ModeQuery: begin
              ram_we = 1'b0;
              state_d = bfknn_pkg::StQRead;
            end
            bfknn_pkg::ModeBase: state_d = bfknn_pkg::StQRead;
            bfknn_pkg::ModeEmit: begin
              emitted_d = '0;
              if (cnt_q == '0) begin
                state_d = bfknn_pkg::StEmitOut;
              end else begin
                sc_d = '0; have_best_d = 1'b0;
                state_d = bfknn_pkg::StEmitScan;
              end
            end
            default: state_d = bfknn_pkg::StIdle;
          endcase
          lastel_d = in_if.payload.mode == bfknn_pkg::ModeQuery;
        end
      end
      bfknn_pkg::StQRead: begin
        if (lastel_q) begin
          // query write; lastel marks mode 0 here
          ram_we = 1'b1;
          if (pos_q == '0) begin
            cnt_d = '0; worst_d = DistMax; vid_d = '0; acc_d = '0;
          end
          pos_d = at_end ? '0 : pos_q + PosW'(1);
          state_d = bfknn_pkg::StIdle;
        end else begin
          state_d = bfknn_pkg::StAcc;
        end
      end
      bfknn_pkg::StAcc: begin
        logic [DW:0] sum;
        sum = {1'b0, acc_q} + (DW+1)'(sq);
        acc_d = sum[DW] ? DistMax : sum[DW-1:0];
        if (at_end) begin
          pos_d = '0;
          vid_d = vid_q + IW'(1);
          cw_dist = acc_d;
          state_d = bfknn_pkg::StIdle;
          acc_d = '0;
          if (cnt_q < eff_k) begin
            cwe = 1'b1; cw_idx = KAw'(cnt_q);
            if (cnt_q == '0 || cw_dist > worst_q) worst_d = cw_dist;
            cnt_d = cnt_q + CntW'(1);
          end else if (cnt_q != '0 && cw_dist < worst_q) begin
            // replace the first entry holding the worst distance
            bd_d = cw_dist; bi_d = vid_q;
            sc_d = '0; have_best_d = 1'b0;
            state_d = bfknn_pkg::StRescan;
          end
        end else begin
          pos_d = pos_q + PosW'(1);
          state_d = bfknn_pkg::StIdle;
        end
      end
      bfknn_pkg::StRescan: begin
        // pass 1: find the first entry equal to worst, overwrite it, then
        // recompute worst on the fly: pd_q tracks the running max
        if (!have_best_q && s_dist == worst_q) begin
          cwe = 1'b1; cw_idx = sc_q; cw_dist = bd_q;
          have_best_d = 1'b1;
        end
        begin
          logic [DW-1:0] ent;
          ent = (!have_best_q && s_dist == worst_q) ? bd_q : s_dist;
          if (sc_q == '0 || ent > pd_q) pd_d = ent;
          if (sc_last) begin
            worst_d = (sc_q == '0 || ent > pd_q) ? ent : pd_q;
            state_d = bfknn_pkg::StIdle;
          end else begin
            sc_d = sc_q + KAw'(1);
          end
        end
      end
      bfknn_pkg::StEmitScan: begin
        if (after_prev && before_best) begin
          best_d = sc_q; bd_d = s_dist; bi_d = s_id; have_best_d = 1'b1;
        end
        if (sc_last) begin
          state_d = bfknn_pkg::StEmitOut;
        end else begin
          sc_d = sc_q + KAw'(1);
        end
      end
      bfknn_pkg::StEmitOut: begin
        if (!ovalid_q || out_if.ready) begin
          ovalid_d = 1'b1;
          if (cnt_q == '0) begin
            oitem_d = '{distance: '0, vector_id: '0, found: 1'b0, last: 1'b1};
            state_d = bfknn_pkg::StIdle;
          end else begin
            oitem_d = '{distance: bd_q, vector_id: bi_q, found: 1'b1,
                        last: (emitted_q + CntW'(1)) == cnt_q};
            emitted_d = emitted_q + CntW'(1);
            pd_d = bd_q; pi_d = bi_q; pk_d = best_q;
            sc_d = '0; have_best_d = 1'b0;
            state_d = ((emitted_q + CntW'(1)) == cnt_q) ? bfknn_pkg::StIdle
                                                        : bfknn_pkg::StEmitScan;
          end
        end
      end
      default: state_d = bfknn_pkg::StIdle;
    endcase
  end

  // replace path writes id from bi_q; append writes the current id
  always_ff @(posedge clk_i) begin
    if (cwe) begin
      cd_q[cw_idx] <= cw_dist;
      ci_q[cw_idx] <= (state_q == bfknn_pkg::StRescan) ? bi_q : vid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfknn_pkg::StIdle;
      k_q <= 5'd16; len_q <= 8'd128;
      pos_q <= '0; acc_q <= '0; vid_q <= '0; cnt_q <= '0; worst_q <= DistMax;
      emitted_q <= '0; have_best_q <= 1'b0; ovalid_q <= 1'b0; lastel_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bfknn_pkg::RegKInUse: k_q <= cfg_data_i[4:0];
          bfknn_pkg::RegVecLen: len_q <= cfg_data_i;
          default: ;
        endcase
      end
      pos_q <= pos_d; acc_q <= acc_d; vid_q <= vid_d; cnt_q <= cnt_d;
      worst_q <= worst_d; emitted_q <= emitted_d; have_best_q <= have_best_d;
      ovalid_q <= ovalid_d; lastel_q <= lastel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; sc_q <= sc_d; best_q <= best_d; bd_q <= bd_d; bi_q <= bi_d;
    pd_q <= pd_d; pi_q <= pi_d; pk_q <= pk_d; oitem_q <= oitem_d;
  end

  assign out_if.valid   = ovalid_q;
  assign out_if.payload = oitem_q;
endmodule

// File: test/tb.sv
// Testbench for the k-nearest-neighbor search unit: predicts readouts and checks each transfer.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bfknn_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [bfknn_pkg::CfgDataW-1:0] cfg_data_i = '0;

  bfknn_in_if in_ch ();
  bfknn_out_if out_ch ();

  brute_force_knn_topk_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [4:0] k_reg;
  logic [7:0] len_reg;
  logic signed [15:0] query_mem [bfknn_pkg::MaxDimDefault];
  int unsigned elem_pos;
  logic [bfknn_pkg::DistW-1:0] acc;
  logic [bfknn_pkg::IdW-1:0] next_id;
  logic [bfknn_pkg::DistW-1:0] cand_dist [bfknn_pkg::MaxKDefault];
  logic [bfknn_pkg::IdW-1:0] cand_id [bfknn_pkg::MaxKDefault];
  int unsigned cand_cnt;
  logic [bfknn_pkg::DistW-1:0] worst;

  bfknn_pkg::out_item_t expected_q [$];
  int unsigned errors = 0;
  int unsigned tx_idle_pct = 0, rx_idle_pct = 0;
  bit rx_hold = 1'b0;
  int unsigned quiet_cycles = 0;

  localparam logic [bfknn_pkg::DistW-1:0] DistMax = '1;

  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > bfknn_pkg::MaxDimDefault) return bfknn_pkg::MaxDimDefault;
    return len_reg;
  endfunction

  function automatic int unsigned eff_k();
    if (k_reg == 0) return 1;
    if (k_reg > bfknn_pkg::MaxKDefault) return bfknn_pkg::MaxKDefault;
    return k_reg;
  endfunction

  function automatic void clear_search();
    cand_cnt = 0;
    worst = DistMax;
    next_id = '0;
    acc = '0;
  endfunction

  function automatic void offer_candidate(logic [bfknn_pkg::DistW-1:0] d,
                                          logic [bfknn_pkg::IdW-1:0] id);
    int unsigned w;
    if (cand_cnt < eff_k()) begin
      cand_dist[cand_cnt] = d;
      cand_id[cand_cnt] = id;
      if (cand_cnt == 0 || d > worst) worst = d;
      cand_cnt++;
      return;
    end
    if (cand_cnt == 0 || d >= worst) return;
    w = 0;
    for (int i = 1; i < cand_cnt; i++) if (cand_dist[i] > cand_dist[w]) w = i;
    cand_dist[w] = d;
    cand_id[w] = id;
    worst = cand_dist[0];
    for (int i = 1; i < cand_cnt; i++) if (cand_dist[i] > worst) worst = cand_dist[i];
  endfunction

  function automatic bit ranks_ahead(int unsigned a, int unsigned b);
    if (cand_dist[a] != cand_dist[b]) return cand_dist[a] < cand_dist[b];
    if (cand_id[a] != cand_id[b]) return cand_id[a] < cand_id[b];
    return a < b;
  endfunction

  function automatic void predict_search(bfknn_pkg::in_item_t it);
    int unsigned p, j, x;
    int unsigned order [bfknn_pkg::MaxKDefault];
    logic signed [17:0] diff;
    logic [bfknn_pkg::DistW:0] sum;
    bfknn_pkg::out_item_t r;
    p = elem_pos % bfknn_pkg::MaxDimDefault;
    case (bfknn_pkg::mode_e'(it.mode))
      bfknn_pkg::ModeQuery: begin
        if (elem_pos == 0) clear_search();
        query_mem[p] = it.value;
        elem_pos = (elem_pos + 1 >= eff_len()) ? 0 : elem_pos + 1;
      end
      bfknn_pkg::ModeBase: begin
        diff = 18'(query_mem[p]) - 18'(signed'(it.value));
        sum = {1'b0, acc} + (bfknn_pkg::DistW + 1)'(diff * diff);
        acc = sum[bfknn_pkg::DistW] ? DistMax : sum[bfknn_pkg::DistW-1:0];
        if (elem_pos + 1 >= eff_len()) begin
          offer_candidate(acc, next_id);
          next_id = next_id + 1'b1;
          acc = '0;
          elem_pos = 0;
        end else begin
          elem_pos++;
        end
      end
      bfknn_pkg::ModeEmit: begin
        if (cand_cnt == 0) begin
          r = '{distance: '0, vector_id: '0, found: 1'b0, last: 1'b1};
          expected_q.push_back(r);
        end else begin
          for (int i = 0; i < cand_cnt; i++) begin
            x = i;
            j = i;
            while (j > 0 && ranks_ahead(x, order[j-1])) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = x;
          end
          for (int i = 0; i < cand_cnt; i++) begin
            r.distance = cand_dist[order[i]];
            r.vector_id = cand_id[order[i]];
            r.found = 1'b1;
            r.last = (i + 1 == cand_cnt);
            expected_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // valid stays high after a transfer; idle cycles, drain and register writes drop it
  task automatic send_item(bfknn_pkg::mode_e m, logic [15:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    predict_search('{mode: m, value: v});
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{mode: m, value: v};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bfknn_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
    in_ch.valid <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bfknn_pkg::RegKInUse) k_reg = val[4:0];
    else len_reg = val;
  endtask

  // wait for all readouts plus the block's rescan time before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // realign to element 0 first so that every element of the length gets written
  task automatic load_query();
    while (elem_pos != 0) send_item(bfknn_pkg::ModeQuery, rand_value());
    for (int i = 0; i < eff_len(); i++) send_item(bfknn_pkg::ModeQuery, rand_value());
  endtask

  task automatic send_vector(bit near);
    int unsigned p;
    for (int i = 0; i < eff_len(); i++) begin
      p = elem_pos % bfknn_pkg::MaxDimDefault;
      send_item(bfknn_pkg::ModeBase,
                near ? 16'(query_mem[p] + $urandom_range(4) - 2) : rand_value());
    end
  endtask

  task automatic test_directed();
    write_reg(bfknn_pkg::RegKInUse, 8'd3);
    write_reg(bfknn_pkg::RegVecLen, 8'd2);
    send_item(bfknn_pkg::ModeEmit, '0);                       // empty store
    send_item(bfknn_pkg::ModeQuery, 16'h7fff);
    send_item(bfknn_pkg::ModeQuery, 16'h8000);
    send_item(bfknn_pkg::ModeBase, 16'h8000);                 // extreme differences
    send_item(bfknn_pkg::ModeBase, 16'h7fff);
    send_item(bfknn_pkg::ModeBase, 16'h7fff);                 // distance zero
    send_item(bfknn_pkg::ModeBase, 16'h8000);
    send_item(bfknn_pkg::ModeBase, 16'h7fff);                 // tie with the previous
    send_item(bfknn_pkg::ModeBase, 16'h8000);
    send_item(bfknn_pkg::ModeBase, 16'h0000);
    send_item(bfknn_pkg::ModeBase, 16'h0000);
    send_item(bfknn_pkg::ModeNone, 16'hffff);                 // ignored
    send_item(bfknn_pkg::ModeEmit, 16'hffff);
    send_item(bfknn_pkg::ModeBase, 16'h7ffe);                 // closer: replaces worst
    send_item(bfknn_pkg::ModeBase, 16'h8000);
    send_item(bfknn_pkg::ModeEmit, '0);
    drain();
    write_reg(bfknn_pkg::RegKInUse, 8'd1);                    // k lowered below count
    send_item(bfknn_pkg::ModeBase, 16'h7fff);
    send_item(bfknn_pkg::ModeBase, 16'h8000);
    send_item(bfknn_pkg::ModeEmit, '0);
    drain();
    write_reg(bfknn_pkg::RegVecLen, 8'd1);                    // length lowered at a vector boundary
    write_reg(bfknn_pkg::RegKInUse, 8'd0);
    send_item(bfknn_pkg::ModeBase, 16'h0001);
    send_item(bfknn_pkg::ModeQuery, 16'h0003);
    send_item(bfknn_pkg::ModeEmit, '0);
    drain();
  endtask

  task automatic run_search(int unsigned n_items);
    int unsigned sent = 0;
    logic [7:0] lens [5] = '{8'd1, 8'd3, 8'd8, 8'd200, 8'd0};
    logic [7:0] ks [5] = '{8'd1, 8'd16, 8'd5, 8'd31, 8'd0};
    while (sent < n_items) begin
      write_reg(bfknn_pkg::RegKInUse, ks[$urandom_range(4)]);
      write_reg(bfknn_pkg::RegVecLen,
                ($urandom_range(9) == 0) ? lens[3] :
                ($urandom_range(9) == 0) ? lens[4] : lens[$urandom_range(2)]);
      if (eff_len() > 8) begin
        // long vectors only once in a while, keep them cheap
        load_query();
        send_vector(1'b0);
        send_item(bfknn_pkg::ModeEmit, '0);
        sent += 2 * eff_len() + 1;
      end else begin
        load_query();
        sent += eff_len();
        repeat ($urandom_range(24, 4)) begin
          case ($urandom_range(9))
            0: begin
              send_item(bfknn_pkg::ModeEmit, 16'($urandom));
              sent += 1;
            end
            1: begin
              send_item(bfknn_pkg::ModeNone, 16'($urandom));
              sent += 1;
            end
            2: if (elem_pos != 0) begin  // mid-vector load
              send_item(bfknn_pkg::ModeQuery, rand_value());
              sent += 1;
            end
            default: begin
              send_vector(1'($urandom_range(1)));
              sent += eff_len();
            end
          endcase
        end
        send_item(bfknn_pkg::ModeEmit, '0);
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_reg(bfknn_pkg::RegKInUse, 8'd16);
    write_reg(bfknn_pkg::RegVecLen, 8'd1);
    load_query();
    repeat (16) send_vector(1'b0);
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (4) send_item(bfknn_pkg::ModeEmit, '0);
    join
    drain();
  endtask

  // receiver
  always @(posedge clk_i) begin
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    bfknn_pkg::out_item_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.distance !== want.distance || got.vector_id !== want.vector_id ||
            got.found !== want.found || got.last !== want.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    k_reg = 5'd16;
    len_reg = 8'd128;
    elem_pos = 0;
    clear_search();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    tx_idle_pct = 20; rx_idle_pct = 84;
    run_search(80);
    tx_idle_pct = 84; rx_idle_pct = 20;
    run_search(80);
    tx_idle_pct = 0; rx_idle_pct = 0;
    test_backpressure();
    run_search(80);
    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
